// ===== design/qnl_pkg.sv =====
// Shared constants for the quaternion nlerp pipeline.
// No dependencies.
`timescale 1ns / 1ps
package qnl_pkg;
  localparam int WEIGHT_W   = 16;
  localparam int WEIGHT_ONE = 32768;
  localparam int NORM_W     = 30;   // normalised magnitude width, top bit at NORM_TOP
  localparam int NORM_TOP   = 29;
  localparam int SQ_W       = 62;   // sum of four squares of NORM_W-bit values
  localparam int ROOT_W     = 31;
endpackage

// ===== design/qnl_blend.sv =====
// Dot-product sign, shortest-arc flip and weighted blend, four stages.
// Depends on qnl_pkg.
`timescale 1ns / 1ps
module qnl_blend import qnl_pkg::*; #(
  parameter int CW = 16,
  localparam int MW = CW + 15
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [3:0][CW-1:0]     a_i,
  input  logic [3:0][CW-1:0]     b_i,
  input  logic [WEIGHT_W-1:0]    weight_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [3:0][MW-1:0]     mag_o,
  output logic [3:0]             neg_o
);
  localparam int NS = 4;
  localparam int PW = 2 * CW;
  localparam int DW = 2 * CW + 2;
  localparam int VW = CW + 18;

  logic [NS-1:0] v_q, en;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = ready_i | (|(~v_q >> k));
    end
  end
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
      end
    end
  end

  // stage 0
  logic [3:0][CW-1:0]     a0_q, b0_q;
  logic [WEIGHT_W-1:0]    t0_q;
  logic [3:0][PW-1:0]     p0_q;
  logic [WEIGHT_W-1:0]    t_clamp;
  logic [3:0][PW-1:0]     p_d;

  always_comb begin
    t_clamp = (32'(weight_i) > WEIGHT_ONE) ? WEIGHT_W'(WEIGHT_ONE) : weight_i;
    for (int i = 0; i < 4; i++) begin
      p_d[i] = PW'($signed(a_i[i]) * $signed(b_i[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a0_q <= a_i;
      b0_q <= b_i;
      t0_q <= t_clamp;
      p0_q <= p_d;
    end
  end

  // stage 1
  logic [3:0][CW-1:0]     a1_q, b1_q;
  logic [WEIGHT_W-1:0]    t1_q;
  logic [WEIGHT_W:0]      w1_q;
  logic                   flip1_q;
  logic signed [DW-1:0]   dot;

  always_comb begin
    dot = '0;
    for (int i = 0; i < 4; i++) begin
      dot = dot + DW'($signed(p0_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      a1_q    <= a0_q;
      b1_q    <= b0_q;
      t1_q    <= t0_q;
      w1_q    <= (WEIGHT_W + 1)'(WEIGHT_ONE) - (WEIGHT_W + 1)'(t0_q);
      flip1_q <= dot[DW-1];
    end
  end

  // stage 2
  logic signed [VW-1:0] u2_q [4];
  logic signed [VW-1:0] s2_q [4];
  logic signed [VW-1:0] u_d [4];
  logic signed [VW-1:0] s_d [4];
  logic signed [CW:0]   bb;
  logic signed [17:0]   ws, ts;

  always_comb begin
    ws = $signed({1'b0, w1_q});
    ts = $signed({2'b00, t1_q});
    for (int i = 0; i < 4; i++) begin
      bb     = (CW + 1)'($signed(b1_q[i]));
      if (flip1_q) bb = -bb;
      u_d[i] = ws * $signed(a1_q[i]);
      s_d[i] = ts * bb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      u2_q <= u_d;
      s2_q <= s_d;
    end
  end

  // stage 3
  logic [3:0][MW-1:0] mag3_q;
  logic [3:0]         neg3_q;
  logic signed [VW-1:0] vs;
  logic [3:0][MW-1:0] mag_d;
  logic [3:0]         neg_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vs       = u2_q[i] + s2_q[i];
      neg_d[i] = vs[VW-1];
      mag_d[i] = neg_d[i] ? MW'(-vs) : MW'(vs);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      mag3_q <= mag_d;
      neg3_q <= neg_d;
    end
  end

  assign mag_o = mag3_q;
  assign neg_o = neg3_q;
endmodule

// ===== design/qnl_norm.sv =====
// Block normalisation of the four magnitudes and sum of squares, five stages.
// Depends on qnl_pkg.
`timescale 1ns / 1ps
module qnl_norm import qnl_pkg::*; #(
  parameter int MW = 31
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [3:0][MW-1:0]     mag_i,
  input  logic [3:0]             neg_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [SQ_W-1:0]        sum_o,
  output logic [3:0][NORM_W-1:0] nmag_o,
  output logic [3:0]             neg_o,
  output logic                   zero_o
);
  localparam int NS = 5;
  localparam int SW = $clog2(MW);
  localparam int XW = MW + NORM_W;

  logic [NS-1:0] v_q, en;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = ready_i | (|(~v_q >> k));
    end
  end
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
      end
    end
  end

  // stage 0: common OR, whose top bit is that of the largest magnitude
  logic [3:0][MW-1:0] mag0_q;
  logic [3:0]         neg0_q;
  logic [MW-1:0]      or0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mag0_q <= mag_i;
      neg0_q <= neg_i;
      or0_q  <= mag_i[0] | mag_i[1] | mag_i[2] | mag_i[3];
    end
  end

  // stage 1: shift distance
  logic [3:0][MW-1:0] mag1_q;
  logic [3:0]         neg1_q;
  logic               zero1_q, right1_q;
  logic [SW-1:0]      amt1_q;
  int                 pos;

  always_comb begin
    pos = 0;
    for (int b = 0; b < MW; b++) begin
      if (or0_q[b]) pos = b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      mag1_q   <= mag0_q;
      neg1_q   <= neg0_q;
      zero1_q  <= (or0_q == '0);
      right1_q <= (pos > NORM_TOP);
      amt1_q   <= (pos > NORM_TOP) ? SW'(pos - NORM_TOP) : SW'(NORM_TOP - pos);
    end
  end

  // stage 2: apply shift
  logic [3:0][NORM_W-1:0] nmag2_q;
  logic [3:0]             neg2_q;
  logic                   zero2_q;
  logic [3:0][NORM_W-1:0] nmag_d;
  logic [XW-1:0]          ext;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ext       = XW'(mag1_q[i]);
      ext       = right1_q ? (ext >> amt1_q) : (ext << amt1_q);
      nmag_d[i] = ext[NORM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      nmag2_q <= nmag_d;
      neg2_q  <= neg1_q;
      zero2_q <= zero1_q;
    end
  end

  // stage 3: squares
  logic [3:0][2*NORM_W-1:0] sq3_q;
  logic [3:0][NORM_W-1:0]   nmag3_q;
  logic [3:0]               neg3_q;
  logic                     zero3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 4; i++) begin
        sq3_q[i] <= nmag2_q[i] * nmag2_q[i];
      end
      nmag3_q <= nmag2_q;
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
    end
  end

  // stage 4: sum
  logic [SQ_W-1:0]        sum4_q;
  logic [3:0][NORM_W-1:0] nmag4_q;
  logic [3:0]             neg4_q;
  logic                   zero4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      sum4_q  <= SQ_W'(sq3_q[0]) + SQ_W'(sq3_q[1]) + SQ_W'(sq3_q[2]) + SQ_W'(sq3_q[3]);
      nmag4_q <= nmag3_q;
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
    end
  end

  assign sum_o  = sum4_q;
  assign nmag_o = nmag4_q;
  assign neg_o  = neg4_q;
  assign zero_o = zero4_q;
endmodule

// ===== design/qnl_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with side-band data.
// Depends on qnl_pkg.
`timescale 1ns / 1ps
module qnl_sqrt import qnl_pkg::*; #(
  parameter int SIDE_W = 125
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [SQ_W-1:0]   sum_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int NS = ROOT_W;

  logic [NS-1:0] v_q, en;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = ready_i | (|(~v_q >> k));
    end
  end
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
      end
    end
  end

  logic [SQ_W-1:0]   rem_q  [NS];
  logic [ROOT_W-1:0] root_q [NS];
  logic [SIDE_W-1:0] side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int J = ROOT_W - 1 - k;
    logic [SQ_W-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_in;
    logic [63:0]       trial;

    if (k == 0) begin : g_first
      assign rem_in  = sum_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = (64'(root_in) << (J + 1)) + (64'd1 << (2 * J));

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        side_q[k] <= side_in;
        if (64'(rem_in) >= trial) begin
          rem_q[k]  <= rem_in - trial[SQ_W-1:0];
          root_q[k] <= root_in | (ROOT_W'(1) << J);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[NS-1];
  assign side_o = side_q[NS-1];
endmodule

// ===== design/qnl_div.sv =====
// Rounded division of each magnitude by the length, one quotient bit per stage,
// then sign, saturation and the zero case. Depends on qnl_pkg.
`timescale 1ns / 1ps
module qnl_div import qnl_pkg::*; #(
  parameter int CW = 16,
  parameter int FB = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [ROOT_W-1:0]      root_i,
  input  logic [3:0][NORM_W-1:0] nmag_i,
  input  logic [3:0]             neg_i,
  input  logic                   zero_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [3:0][CW-1:0]     r_o,
  output logic                   degenerate_o
);
  localparam int NQ = FB + 1;
  localparam int NS = FB + 3;
  localparam int RW = NORM_W + FB + 1;
  localparam logic [32:0] LIM = 33'd1 << (CW - 1);

  logic [NS-1:0] v_q, en;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = ready_i | (|(~v_q >> k));
    end
  end
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
      end
    end
  end

  logic [3:0][RW-1:0]  rem_q  [NQ+1];
  logic [3:0][NQ-1:0]  quo_q  [NQ+1];
  logic [ROOT_W-1:0]   m_q    [NQ+1];
  logic [3:0]          neg_q  [NQ+1];
  logic                zero_q [NQ+1];

  // numerator with half the divisor added for rounding
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 4; i++) begin
        rem_q[0][i] <= (RW'(nmag_i[i]) << FB) + RW'(root_i >> 1);
      end
      quo_q[0]  <= '0;
      m_q[0]    <= root_i;
      neg_q[0]  <= neg_i;
      zero_q[0] <= zero_i;
    end
  end

  for (genvar k = 1; k <= NQ; k++) begin : g_stage
    localparam int J = NQ - k;
    logic [RW-1:0] dsh;
    assign dsh = RW'(m_q[k-1]) << J;

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        m_q[k]    <= m_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
        for (int i = 0; i < 4; i++) begin
          if (rem_q[k-1][i] >= dsh) begin
            rem_q[k][i] <= rem_q[k-1][i] - dsh;
            quo_q[k][i] <= quo_q[k-1][i] | (NQ'(1) << J);
          end else begin
            rem_q[k][i] <= rem_q[k-1][i];
            quo_q[k][i] <= quo_q[k-1][i];
          end
        end
      end
    end
  end

  logic [3:0][CW-1:0] r_q, r_d;
  logic               deg_q;
  logic [32:0]        qx;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qx = 33'(quo_q[NQ][i]);
      if (zero_q[NQ]) begin
        r_d[i] = '0;
      end else if (neg_q[NQ][i]) begin
        r_d[i] = (qx > LIM) ? {1'b1, {(CW-1){1'b0}}} : -qx[CW-1:0];
      end else begin
        r_d[i] = (qx > LIM - 33'd1) ? {1'b0, {(CW-1){1'b1}}} : qx[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      r_q   <= r_d;
      deg_q <= zero_q[NQ];
    end
  end

  assign r_o          = r_q;
  assign degenerate_o = deg_q;
endmodule

// ===== design/quaternion_nlerp.sv =====
// Top level: normalised linear interpolation of two fixed-point quaternions.
// Depends on qnl_pkg, qnl_blend, qnl_norm, qnl_sqrt and qnl_div.
//
//   channel  | handshake          | payload
//   input    | valid_i / ready_o  | a_{w,x,y,z}_i, b_{w,x,y,z}_i, weight_i
//   output   | valid_o / ready_i  | r_{w,x,y,z}_o, degenerate_o
//
// One transaction per cycle sustained while the output is not stalled; the pipeline has
// 4 blend, 5 normalise, 31 square-root bit stages and FRAC_BITS + 3 divide stages.
// Reset clears only the stage valid bits. A stall holds every full stage from the
// output backwards; empty stages still fill, so no transaction is lost or repeated.
`timescale 1ns / 1ps
module quaternion_nlerp import qnl_pkg::*; #(
  parameter int COMP_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [COMP_WIDTH-1:0] a_w_i,
  input  logic [COMP_WIDTH-1:0] a_x_i,
  input  logic [COMP_WIDTH-1:0] a_y_i,
  input  logic [COMP_WIDTH-1:0] a_z_i,
  input  logic [COMP_WIDTH-1:0] b_w_i,
  input  logic [COMP_WIDTH-1:0] b_x_i,
  input  logic [COMP_WIDTH-1:0] b_y_i,
  input  logic [COMP_WIDTH-1:0] b_z_i,
  input  logic [WEIGHT_W-1:0]   weight_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [COMP_WIDTH-1:0] r_w_o,
  output logic [COMP_WIDTH-1:0] r_x_o,
  output logic [COMP_WIDTH-1:0] r_y_o,
  output logic [COMP_WIDTH-1:0] r_z_o,
  output logic                  degenerate_o
);
  localparam int MW     = COMP_WIDTH + 15;
  localparam int SIDE_W = 4 * NORM_W + 5;

  logic                       bl_valid, bl_ready;
  logic [3:0][MW-1:0]         bl_mag;
  logic [3:0]                 bl_neg;
  logic                       nm_valid, nm_ready;
  logic [SQ_W-1:0]            nm_sum;
  logic [3:0][NORM_W-1:0]     nm_nmag;
  logic [3:0]                 nm_neg;
  logic                       nm_zero;
  logic                       sq_valid, sq_ready;
  logic [ROOT_W-1:0]          sq_root;
  logic [SIDE_W-1:0]          sq_side;
  logic [3:0][COMP_WIDTH-1:0] res;

  qnl_blend #(.CW(COMP_WIDTH)) u_blend (
    .clk_i, .rst_ni,
    .valid_i, .ready_o,
    .a_i      ({a_z_i, a_y_i, a_x_i, a_w_i}),
    .b_i      ({b_z_i, b_y_i, b_x_i, b_w_i}),
    .weight_i,
    .valid_o  (bl_valid),
    .ready_i  (bl_ready),
    .mag_o    (bl_mag),
    .neg_o    (bl_neg)
  );

  qnl_norm #(.MW(MW)) u_norm (
    .clk_i, .rst_ni,
    .valid_i  (bl_valid),
    .ready_o  (bl_ready),
    .mag_i    (bl_mag),
    .neg_i    (bl_neg),
    .valid_o  (nm_valid),
    .ready_i  (nm_ready),
    .sum_o    (nm_sum),
    .nmag_o   (nm_nmag),
    .neg_o    (nm_neg),
    .zero_o   (nm_zero)
  );

  qnl_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk_i, .rst_ni,
    .valid_i  (nm_valid),
    .ready_o  (nm_ready),
    .sum_i    (nm_sum),
    .side_i   ({nm_zero, nm_neg, nm_nmag}),
    .valid_o  (sq_valid),
    .ready_i  (sq_ready),
    .root_o   (sq_root),
    .side_o   (sq_side)
  );

  qnl_div #(.CW(COMP_WIDTH), .FB(FRAC_BITS)) u_div (
    .clk_i, .rst_ni,
    .valid_i      (sq_valid),
    .ready_o      (sq_ready),
    .root_i       (sq_root),
    .nmag_i       (sq_side[4*NORM_W-1:0]),
    .neg_i        (sq_side[4*NORM_W+3:4*NORM_W]),
    .zero_i       (sq_side[SIDE_W-1]),
    .valid_o,
    .ready_i,
    .r_o          (res),
    .degenerate_o
  );

  assign r_w_o = res[0];
  assign r_x_o = res[1];
  assign r_y_o = res[2];
  assign r_z_o = res[3];
endmodule
